FILE: rtl/csq_pkg.sv
// Shared constants, codes and types of the coalescing send queue.
package csq_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int MCNT_W      = $clog2(QUEUE_DEPTH + 2);
   localparam int CMP_W       = (MCNT_W > 6) ? MCNT_W : 6;
   localparam int RES_CAP     = 34;

   localparam int ID_W    = 16;
   localparam int KEY_W   = 32;
   localparam int LEN_W   = 16;
   localparam int CLIM_W  = 6;
   localparam int SLIM_W  = 24;
   localparam int DONE_W  = 6;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_GATHER = 2'd1,
      OP_ACK    = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_STATUS  = 2'd0,
      KIND_CHUNK   = 2'd1,
      KIND_DONE    = 2'd2,
      KIND_SUMMARY = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_ADDED    = 2'd0,
      ST_REPLACED = 2'd1,
      ST_REJECTED = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_COUNT_LIMIT = 1'b0,
      CSR_SIZE_LIMIT  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] length;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } mem_wr_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        status;
      logic [ID_W-1:0]   id;
      logic [LEN_W-1:0]  offset;
      logic [LEN_W-1:0]  length;
      logic [DONE_W-1:0] count;
      logic              empty;
      logic              last;
   } rsp_type;

   typedef enum logic [15:0] {
      S_IDLE     = 16'h0001,
      S_SRCH_RD  = 16'h0002,
      S_SRCH_CHK = 16'h0004,
      S_ADD      = 16'h0008,
      S_REPL     = 16'h0010,
      S_SH_RD    = 16'h0020,
      S_SH_WR    = 16'h0040,
      S_REPL_FIN = 16'h0080,
      S_GATH_P   = 16'h0100,
      S_GATH_RD  = 16'h0200,
      S_GATH_EM  = 16'h0400,
      S_TERM     = 16'h0800,
      S_ACK_P    = 16'h1000,
      S_ACK_RD   = 16'h2000,
      S_ACK_CHK  = 16'h4000,
      S_ACK_FIN  = 16'h8000
   } state_type;

endpackage

FILE: rtl/coalescing_send_queue.sv
// Coalescing send queue: descriptor queue with count and byte limits.
//
//   channel | direction | handshake          | contents
//   req     | in        | req_valid/stall    | operation, id, key, length, byte count
//   rsp     | out       | rsp_valid/stall    | one result item per transfer
//   csr     | in        | csr_write          | count_limit (0), size_limit (1)
//
// Each memory visit is an address state followed by a state that uses the registered data.
// An unkeyed add visits no entry. A keyed add visits each entry searched, plus each entry
// moved up on replace. A gather visits each entry listed. An acknowledge visits each entry
// drained plus each remaining entry moved to the front.
// Reset is synchronous; stall on rsp holds the sequencer at its next result.
module coalescing_send_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_operation,
   input  logic [csq_pkg::ID_W-1:0]     req_message_id,
   input  logic signed [csq_pkg::KEY_W-1:0] req_message_key,
   input  logic [csq_pkg::LEN_W-1:0]    req_message_length,
   input  logic [csq_pkg::LEN_W-1:0]    req_byte_count,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_kind,
   output logic [1:0]                   rsp_status,
   output logic [csq_pkg::ID_W-1:0]     rsp_out_message_id,
   output logic [csq_pkg::LEN_W-1:0]    rsp_chunk_offset,
   output logic [csq_pkg::LEN_W-1:0]    rsp_chunk_length,
   output logic [csq_pkg::DONE_W-1:0]   rsp_completed_count,
   output logic                         rsp_queue_empty,
   output logic                         rsp_last,
   input  logic                         csr_write,
   input  logic                         csr_index,
   input  logic [csq_pkg::SLIM_W-1:0]   csr_data
);
   import csq_pkg::*;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    qcnt_ff, qcnt_in;
   logic [ID_W-1:0]     pid_ff, pid_in;
   logic [LEN_W-1:0]    plen_ff, plen_in;
   logic [LEN_W-1:0]    ppos_ff, ppos_in;
   logic [MCNT_W-1:0]   mcnt_ff, mcnt_in;
   logic [SLIM_W-1:0]   total_ff, total_in;
   logic [CLIM_W-1:0]   climit_ff;
   logic [SLIM_W-1:0]   slimit_ff;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    bytes_ff, bytes_in;
   logic                ack_ff, ack_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    shamt_ff, shamt_in;
   logic [LEN_W-1:0]    old_ff, old_in;
   logic [LEN_W-1:0]    pos_ff, pos_in;
   logic [LEN_W-1:0]    sent_ff, sent_in;
   logic [LEN_W-1:0]    drained_ff, drained_in;
   logic [DONE_W-1:0]   done_ff, done_in;
   logic [5:0]          nres_ff, nres_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   mem_wr_type          mem_wr;
   entry_type           ent;
   rsp_type             e;
   logic                emit;
   logic                slot;
   logic [LEN_W-1:0]    rem_p;
   logic [LEN_W-1:0]    take_p;
   logic [LEN_W-1:0]    avail;
   logic [LEN_W-1:0]    take_e;
   logic [SLIM_W:0]     sum;
   logic [SLIM_W:0]     repl_sum;
   logic                add_rej;
   logic                repl_rej;
   logic                need;
   logic [CNT_W-1:0]    wdst;
   logic [CNT_W-1:0]    qlast;
   logic [SLIM_W-1:0]   total_ack;

   csq_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (ent)
   );

   assign slot     = !rsp_valid_ff || !rsp_stall;
   assign rem_p    = (plen_ff > ppos_ff) ? plen_ff - ppos_ff : '0;
   assign take_p   = (rem_p < bytes_ff) ? rem_p : bytes_ff;
   assign avail    = bytes_ff - pos_ff;
   assign take_e   = (ent.length < avail) ? ent.length : avail;
   assign sum      = {1'b0, total_ff} + (SLIM_W+1)'(len_ff);
   assign repl_sum = sum - (SLIM_W+1)'(old_ff);
   assign add_rej  = (CMP_W'(mcnt_ff) >= CMP_W'(climit_ff))
                     || (qcnt_ff == CNT_W'(QUEUE_DEPTH))
                     || (sum > {1'b0, slimit_ff});
   assign repl_rej = (sum < (SLIM_W+1)'(old_ff)) || (repl_sum > {1'b0, slimit_ff});
   assign need     = nres_ff < 6'(RES_CAP - 1);
   assign wdst     = idx_ff - shamt_ff;
   assign qlast    = qcnt_ff - CNT_W'(1);
   assign total_ack = (total_ff > SLIM_W'(drained_ff)) ? total_ff - SLIM_W'(drained_ff) : '0;

   always_comb begin
      state_in   = state_ff;
      qcnt_in    = qcnt_ff;
      pid_in     = pid_ff;
      plen_in    = plen_ff;
      ppos_in    = ppos_ff;
      mcnt_in    = mcnt_ff;
      total_in   = total_ff;
      id_in      = id_ff;
      key_in     = key_ff;
      len_in     = len_ff;
      bytes_in   = bytes_ff;
      ack_in     = ack_ff;
      idx_in     = idx_ff;
      shamt_in   = shamt_ff;
      old_in     = old_ff;
      pos_in     = pos_ff;
      sent_in    = sent_ff;
      drained_in = drained_ff;
      done_in    = done_ff;
      nres_in    = nres_ff;
      mem_wr     = '0;
      emit       = 1'b0;
      e          = '0;
      e.empty    = (total_ff == '0);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               id_in      = req_message_id;
               key_in     = req_message_key;
               len_in     = req_message_length;
               bytes_in   = req_byte_count;
               sent_in    = req_byte_count;
               ack_in     = (req_operation == OP_ACK);
               idx_in     = '0;
               pos_in     = '0;
               nres_in    = '0;
               drained_in = '0;
               done_in    = '0;
               unique case (req_operation)
                  OP_ADD:    state_in = req_message_key[KEY_W-1] ? S_ADD : S_SRCH_RD;
                  OP_GATHER: state_in = S_GATH_P;
                  OP_ACK:    state_in = S_ACK_P;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_SRCH_RD: begin
            state_in = (idx_ff >= qcnt_ff) ? S_ADD : S_SRCH_CHK;
         end
         S_SRCH_CHK: begin
            if (ent.key == key_ff) begin
               old_in   = ent.length;
               idx_in   = idx_ff + CNT_W'(1);
               shamt_in = CNT_W'(1);
               state_in = S_REPL;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_SRCH_RD;
            end
         end
         S_ADD: begin
            if (slot) begin
               emit     = 1'b1;
               e.kind   = KIND_STATUS;
               e.last   = 1'b1;
               if (add_rej) begin
                  e.status = ST_REJECTED;
               end else begin
                  e.status    = ST_ADDED;
                  mem_wr.we   = 1'b1;
                  mem_wr.addr = qcnt_ff[IDX_W-1:0];
                  mem_wr.data = '{id: id_ff, key: key_ff, length: len_ff};
                  qcnt_in     = qcnt_ff + CNT_W'(1);
                  mcnt_in     = mcnt_ff + MCNT_W'(1);
                  total_in    = sum[SLIM_W-1:0];
                  e.empty     = (sum[SLIM_W-1:0] == '0);
               end
               state_in = S_IDLE;
            end
         end
         S_REPL: begin
            if (repl_rej) begin
               if (slot) begin
                  emit     = 1'b1;
                  e.kind   = KIND_STATUS;
                  e.status = ST_REJECTED;
                  e.last   = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_SH_RD;
            end
         end
         S_SH_RD: begin
            if (idx_ff >= qcnt_ff) begin
               state_in = ack_ff ? S_ACK_FIN : S_REPL_FIN;
            end else begin
               state_in = S_SH_WR;
            end
         end
         S_SH_WR: begin
            mem_wr.we   = 1'b1;
            mem_wr.addr = wdst[IDX_W-1:0];
            mem_wr.data = ent;
            idx_in      = idx_ff + CNT_W'(1);
            state_in    = S_SH_RD;
         end
         S_REPL_FIN: begin
            if (slot) begin
               mem_wr.we   = 1'b1;
               mem_wr.addr = qlast[IDX_W-1:0];
               mem_wr.data = '{id: id_ff, key: key_ff, length: len_ff};
               total_in    = repl_sum[SLIM_W-1:0];
               emit        = 1'b1;
               e.kind      = KIND_STATUS;
               e.status    = ST_REPLACED;
               e.last      = 1'b1;
               e.empty     = (repl_sum[SLIM_W-1:0] == '0);
               state_in    = S_IDLE;
            end
         end
         S_GATH_P: begin
            if (rem_p != '0 && bytes_ff != '0) begin
               if (slot) begin
                  emit     = 1'b1;
                  e.kind   = KIND_CHUNK;
                  e.id     = pid_ff;
                  e.offset = ppos_ff;
                  e.length = take_p;
                  pos_in   = take_p;
                  nres_in  = 6'd1;
                  state_in = S_GATH_RD;
               end
            end else begin
               state_in = S_GATH_RD;
            end
         end
         S_GATH_RD: begin
            if (idx_ff >= qcnt_ff || pos_ff >= bytes_ff || !need) begin
               state_in = S_TERM;
            end else begin
               state_in = S_GATH_EM;
            end
         end
         S_GATH_EM: begin
            if (slot) begin
               emit     = 1'b1;
               e.kind   = KIND_CHUNK;
               e.id     = ent.id;
               e.length = take_e;
               pos_in   = pos_ff + take_e;
               idx_in   = idx_ff + CNT_W'(1);
               nres_in  = nres_ff + 6'd1;
               state_in = S_GATH_RD;
            end
         end
         S_TERM: begin
            if (slot) begin
               emit     = 1'b1;
               e.kind   = KIND_CHUNK;
               e.last   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ACK_P: begin
            if (sent_ff != '0 && rem_p != '0) begin
               if (rem_p <= sent_ff) begin
                  if (slot) begin
                     ppos_in    = plen_ff;
                     mcnt_in    = (mcnt_ff != '0) ? mcnt_ff - MCNT_W'(1) : mcnt_ff;
                     done_in    = DONE_W'(1);
                     nres_in    = 6'd1;
                     emit       = 1'b1;
                     e.kind     = KIND_DONE;
                     e.id       = pid_ff;
                     sent_in    = sent_ff - rem_p;
                     drained_in = rem_p;
                     state_in   = S_ACK_RD;
                  end
               end else begin
                  ppos_in    = ppos_ff + sent_ff;
                  drained_in = sent_ff;
                  sent_in    = '0;
                  state_in   = S_ACK_RD;
               end
            end else begin
               state_in = S_ACK_RD;
            end
         end
         S_ACK_RD: begin
            if (sent_ff == '0 || idx_ff >= qcnt_ff) begin
               shamt_in = idx_ff;
               state_in = (idx_ff == '0) ? S_ACK_FIN : S_SH_RD;
            end else begin
               state_in = S_ACK_CHK;
            end
         end
         S_ACK_CHK: begin
            if (ent.length <= sent_ff) begin
               if (!need || slot) begin
                  if (need) begin
                     emit    = 1'b1;
                     e.kind  = KIND_DONE;
                     e.id    = ent.id;
                     nres_in = nres_ff + 6'd1;
                  end
                  done_in    = done_ff + DONE_W'(1);
                  mcnt_in    = (mcnt_ff != '0) ? mcnt_ff - MCNT_W'(1) : mcnt_ff;
                  sent_in    = sent_ff - ent.length;
                  drained_in = drained_ff + ent.length;
                  idx_in     = idx_ff + CNT_W'(1);
                  state_in   = S_ACK_RD;
               end
            end else begin
               pid_in     = ent.id;
               plen_in    = ent.length;
               ppos_in    = sent_ff;
               drained_in = drained_ff + sent_ff;
               sent_in    = '0;
               idx_in     = idx_ff + CNT_W'(1);
               state_in   = S_ACK_RD;
            end
         end
         S_ACK_FIN: begin
            if (slot) begin
               qcnt_in  = qcnt_ff - shamt_ff;
               total_in = total_ack;
               emit     = 1'b1;
               e.kind   = KIND_SUMMARY;
               e.count  = done_ff;
               e.empty  = (total_ack == '0);
               e.last   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         qcnt_ff      <= '0;
         pid_ff       <= '0;
         plen_ff      <= '0;
         ppos_ff      <= '0;
         mcnt_ff      <= '0;
         total_ff     <= '0;
         climit_ff    <= CLIM_W'(32);
         slimit_ff    <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         qcnt_ff  <= qcnt_in;
         pid_ff   <= pid_in;
         plen_ff  <= plen_in;
         ppos_ff  <= ppos_in;
         mcnt_ff  <= mcnt_in;
         total_ff <= total_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_COUNT_LIMIT: climit_ff <= csr_data[CLIM_W-1:0];
               CSR_SIZE_LIMIT:  slimit_ff <= csr_data;
               default:         slimit_ff <= slimit_ff;
            endcase
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff      <= id_in;
      key_ff     <= key_in;
      len_ff     <= len_in;
      bytes_ff   <= bytes_in;
      ack_ff     <= ack_in;
      idx_ff     <= idx_in;
      shamt_ff   <= shamt_in;
      old_ff     <= old_in;
      pos_ff     <= pos_in;
      sent_ff    <= sent_in;
      drained_ff <= drained_in;
      done_ff    <= done_in;
      nres_ff    <= nres_in;
      if (emit) begin
         rsp_ff <= e;
      end
   end

   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_ff.kind;
   assign rsp_status          = rsp_ff.status;
   assign rsp_out_message_id  = rsp_ff.id;
   assign rsp_chunk_offset    = rsp_ff.offset;
   assign rsp_chunk_length    = rsp_ff.length;
   assign rsp_completed_count = rsp_ff.count;
   assign rsp_queue_empty     = rsp_ff.empty;
   assign rsp_last            = rsp_ff.last;

endmodule

FILE: rtl/csq_mem.sv
// Descriptor memory: one write port, one registered read port.
module csq_mem (
   input  logic                         clock,
   input  csq_pkg::mem_wr_type          wr,
   input  logic [csq_pkg::IDX_W-1:0]    rd_addr,
   output csq_pkg::entry_type           rd_data
);
   import csq_pkg::*;

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench of the coalescing send queue: random and directed items, predicted results.
`timescale 1ns / 100ps

module testbench;
   import csq_pkg::*;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] id;
      logic [31:0] key;
      logic [15:0] len;
      logic [15:0] bytes;
   } item_type;

   localparam int PEND_SIZE = 1024;
   localparam int EXP_SIZE  = 256;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_operation = 0;
   logic [15:0] req_message_id = 0;
   logic signed [31:0] req_message_key = 0;
   logic [15:0] req_message_length = 0;
   logic [15:0] req_byte_count = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0] rsp_kind;
   logic [1:0] rsp_status;
   logic [15:0] rsp_out_message_id;
   logic [15:0] rsp_chunk_offset;
   logic [15:0] rsp_chunk_length;
   logic [5:0] rsp_completed_count;
   logic rsp_queue_empty;
   logic rsp_last;
   logic csr_write = 0;
   logic csr_index = 0;
   logic [23:0] csr_data = 0;

   coalescing_send_queue DUT (.*);

   initial forever #10 clock = ~clock;

   // predictor state
   logic [15:0] q_id[QUEUE_DEPTH];
   logic [31:0] q_key[QUEUE_DEPTH];
   logic [15:0] q_len[QUEUE_DEPTH];
   int unsigned q_n, p_id, p_len, p_pos, m_count, t_bytes, lim_count, lim_size;

   item_type pend_mem[PEND_SIZE];
   int unsigned pend_head = 0, pend_tail = 0;
   rsp_type expected_mem[EXP_SIZE];
   int unsigned exp_head = 0, exp_tail = 0;
   int errors = 0, cycles = 0, n_items = 0, n_rsp = 0;
   int send_idle = 6, recv_idle = 84;
   int hold_cycles = 0;
   bit hold_req = 0;

   function automatic void queue_item(item_type it);
      pend_mem[pend_tail % PEND_SIZE] = it;
      pend_tail++;
   endfunction

   function automatic void push_rsp(logic [1:0] k, logic [1:0] st, int unsigned id,
                                    int unsigned off, int unsigned ln, int unsigned cnt,
                                    bit lst);
      rsp_type r;
      r.kind = k; r.status = st; r.id = id[15:0]; r.offset = off[15:0];
      r.length = ln[15:0]; r.count = cnt[5:0]; r.empty = (t_bytes == 0); r.last = lst;
      expected_mem[exp_tail % EXP_SIZE] = r;
      exp_tail++;
   endfunction

   function automatic void drop_entry(int unsigned i);
      for (int unsigned j = i; j + 1 < q_n; j++) begin
         q_id[j] = q_id[j+1]; q_key[j] = q_key[j+1]; q_len[j] = q_len[j+1];
      end
      if (q_n > 0) q_n--;
   endfunction

   function automatic logic [1:0] admit(item_type it);
      int unsigned sum;
      if (m_count >= lim_count || q_n >= QUEUE_DEPTH) return ST_REJECTED;
      sum = t_bytes + it.len;
      if (sum > lim_size) return ST_REJECTED;
      q_id[q_n] = it.id; q_key[q_n] = it.key; q_len[q_n] = it.len; q_n++;
      t_bytes = sum; m_count++;
      return ST_ADDED;
   endfunction

   function automatic void predict_queue(item_type it);
      int unsigned i, sum, pos, rem, take, sent, drained, done, n, fid;
      n = 0;
      case (it.op)
         OP_ADD: begin
            logic [1:0] st;
            if (it.key[31]) st = admit(it);
            else begin
               for (i = 0; i < q_n; i++) if (q_key[i] == it.key) break;
               if (i >= q_n) st = admit(it);
               else if (t_bytes + it.len < q_len[i]) st = ST_REJECTED;
               else begin
                  sum = t_bytes + it.len - q_len[i];
                  if (sum > lim_size) st = ST_REJECTED;
                  else begin
                     drop_entry(i);
                     q_id[q_n] = it.id; q_key[q_n] = it.key; q_len[q_n] = it.len; q_n++;
                     t_bytes = sum; st = ST_REPLACED;
                  end
               end
            end
            push_rsp(KIND_STATUS, st, 0, 0, 0, 0, 1);
         end
         OP_GATHER: begin
            pos = 0;
            rem = (p_len > p_pos) ? p_len - p_pos : 0;
            if (rem > 0 && pos < it.bytes) begin
               take = (rem < it.bytes - pos) ? rem : it.bytes - pos;
               push_rsp(KIND_CHUNK, 0, p_id, p_pos, take, 0, 0); n++;
               pos += take;
            end
            for (i = 0; i < q_n; i++) begin
               if (pos >= it.bytes || n >= RES_CAP - 1) break;
               rem = q_len[i];
               take = (rem < it.bytes - pos) ? rem : it.bytes - pos;
               push_rsp(KIND_CHUNK, 0, q_id[i], 0, take, 0, 0); n++;
               pos += take;
            end
            push_rsp(KIND_CHUNK, 0, 0, 0, 0, 0, 1);
         end
         OP_ACK: begin
            sent = it.bytes; drained = 0; done = 0;
            rem = (p_len > p_pos) ? p_len - p_pos : 0;
            if (sent > 0 && rem > 0) begin
               if (rem <= sent) begin
                  p_pos = p_len;
                  if (m_count > 0) m_count--;
                  done++;
                  push_rsp(KIND_DONE, 0, p_id, 0, 0, 0, 0);
                  sent -= rem; drained += rem;
               end else begin
                  p_pos += sent; drained += sent; sent = 0;
               end
            end
            while (sent > 0 && q_n > 0) begin
               fid = q_id[0]; rem = q_len[0];
               if (rem <= sent) begin
                  drop_entry(0);
                  if (m_count > 0) m_count--;
                  done++;
                  push_rsp(KIND_DONE, 0, fid, 0, 0, 0, 0);
                  sent -= rem; drained += rem;
               end else begin
                  p_id = fid; p_len = rem; p_pos = sent;
                  drop_entry(0);
                  drained += sent; sent = 0;
               end
            end
            t_bytes = (t_bytes > drained) ? t_bytes - drained : 0;
            push_rsp(KIND_SUMMARY, 0, 0, 0, 0, done, 1);
         end
         default: ;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_queue({req_operation, req_message_id, req_message_key,
                           req_message_length, req_byte_count});
            n_items++;
         end
         if (!req_valid || !req_stall) begin
            if (pend_tail != pend_head && !hold_req && $urandom_range(99) >= send_idle) begin
               item_type it;
               it = pend_mem[pend_head % PEND_SIZE];
               pend_head++;
               req_valid <= 1;
               req_operation <= it.op;
               req_message_id <= it.id;
               req_message_key <= it.key;
               req_message_length <= it.len;
               req_byte_count <= it.bytes;
            end else req_valid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_type got, want;
            got = {rsp_kind, rsp_status, rsp_out_message_id, rsp_chunk_offset,
                   rsp_chunk_length, rsp_completed_count, rsp_queue_empty, rsp_last};
            n_rsp++;
            if (exp_tail == exp_head) begin
               errors++;
               if (errors <= 10) $display("unexpected item %h", got);
            end else begin
               want = expected_mem[exp_head % EXP_SIZE];
               exp_head++;
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1;
         end else rsp_stall <= ($urandom_range(99) < recv_idle);
      end
      if (cycles > 2000000) begin
         $display("timeout");
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, int unsigned val);
      @(posedge clock);
      csr_write <= 1; csr_index <= idx; csr_data <= val[23:0];
      @(posedge clock);
      csr_write <= 0;
      if (idx == CSR_COUNT_LIMIT) lim_count = val & 63;
      else lim_size = val & 24'hFFFFFF;
   endtask

   task automatic drain_all();
      while (pend_tail != pend_head || req_valid || exp_tail != exp_head) @(negedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic item_type rand_item(int keyspace);
      item_type it;
      int r;
      r = $urandom_range(99);
      it.id = 16'($urandom);
      it.bytes = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(300));
      it.len = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(120));
      it.key = ($urandom_range(2) == 0) ? $urandom | 32'h8000_0000 : $urandom_range(keyspace);
      if ($urandom_range(19) == 0) it.key = $urandom;
      if (r < 55) it.op = OP_ADD;
      else if (r < 75) it.op = OP_GATHER;
      else if (r < 97) it.op = OP_ACK;
      else it.op = OP_NONE;
      return it;
   endfunction

   initial begin
      item_type it;
      q_n = 0; p_id = 0; p_len = 0; p_pos = 0; m_count = 0; t_bytes = 0;
      lim_count = 32; lim_size = 24'hFFFFFF;
      repeat (4) @(posedge clock);
      reset <= 0;
      // directed
      queue_item('{OP_GATHER, 0, 0, 0, 0});
      queue_item('{OP_ACK, 0, 0, 0, 100});
      queue_item('{OP_ADD, 16'hFFFF, 32'h8000_0000, 16'hFFFF, 0});
      queue_item('{OP_ADD, 1, 32'h7FFF_FFFF, 0, 0});
      queue_item('{OP_ADD, 2, 5, 10, 0});
      queue_item('{OP_ADD, 3, 5, 20, 0});
      queue_item('{OP_ADD, 4, 32'hFFFF_FFFF, 0, 16'hFFFF});
      queue_item('{OP_GATHER, 0, 0, 0, 16'hFFFF});
      queue_item('{OP_GATHER, 0, 0, 0, 7});
      queue_item('{OP_ACK, 0, 0, 0, 100});
      queue_item('{OP_GATHER, 0, 0, 0, 16'hFFFF});
      queue_item('{OP_ACK, 0, 0, 0, 16'hFFFF});
      queue_item('{OP_ADD, 5, 32'h8000_0001, 0, 0});
      queue_item('{OP_ADD, 6, 32'h8000_0002, 8, 0});
      queue_item('{OP_ACK, 0, 0, 0, 0});
      queue_item('{OP_NONE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF});
      queue_item('{OP_ACK, 0, 0, 0, 16'hFFFF});
      drain_all();
      // fill to the array limit, with a long receiver hold-off
      hold_cycles = 3000;
      for (int i = 0; i < 36; i++)
         queue_item('{OP_ADD, i[15:0], 32'h8000_0000 | i, 16'(i), 0});
      queue_item('{OP_GATHER, 0, 0, 0, 16'hFFFF});
      queue_item('{OP_ACK, 0, 0, 0, 3});
      queue_item('{OP_ACK, 0, 0, 0, 16'hFFFF});
      drain_all();
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_reg(CSR_COUNT_LIMIT, 0); write_reg(CSR_SIZE_LIMIT, 0); end
            1: begin write_reg(CSR_COUNT_LIMIT, 4); write_reg(CSR_SIZE_LIMIT, 400); end
            2: begin write_reg(CSR_COUNT_LIMIT, 63); write_reg(CSR_SIZE_LIMIT, 24'hFFFFFF); end
            3: begin
               send_idle = 84; recv_idle = 6;
               write_reg(CSR_COUNT_LIMIT, 10); write_reg(CSR_SIZE_LIMIT, 1000);
            end
            4: begin write_reg(CSR_COUNT_LIMIT, 2); write_reg(CSR_SIZE_LIMIT, 150); end
            5: begin
               send_idle = 0; recv_idle = 0;
               write_reg(CSR_COUNT_LIMIT, 32); write_reg(CSR_SIZE_LIMIT, 5000);
            end
         endcase
         for (int i = 0; i < 62; i++) begin
            it = rand_item(ph < 3 ? 6 : 40);
            queue_item(it);
         end
         if (ph == 2) begin
            while (pend_tail - pend_head > 30) @(posedge clock);
            hold_req = 1;
            while (req_valid || exp_tail != exp_head) @(negedge clock);
            hold_req = 0;
         end
         drain_all();
      end
      $display("covered %0d items and %0d result items over seven limit settings",
               n_items, n_rsp);
      if (errors == 0 && exp_tail == exp_head) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
